>>> rtl/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg - shared types and constants of the glyph row blitter
// Field widths, configuration register codes, the config bundle and the
// draw descriptor that travels from the front end to the pixel sequencer.
// ----------------------------------------------------------------------------
package grb_pkg;

    localparam int GW       = 16;   // pixels per glyph row, rows per glyph
    localparam int GCW      = 4;    // column / row index width
    localparam int GI_W     = 10;   // glyph index width
    localparam int PX_W     = 9;    // pixel_x field width
    localparam int PY_W     = 8;    // pixel_y field width
    localparam int CLR_W    = 8;    // palette index width
    localparam int CFG_DW   = 11;   // widest register
    localparam int CFG_IW   = 3;    // register index width
    localparam int QDEPTH   = 4;    // descriptor queue depth
    localparam int QPW      = 2;    // queue pointer width
    localparam int QCW      = 3;    // queue count width

    typedef enum logic [CFG_IW-1:0] {
        REG_FG_COLOR     = 3'd0,
        REG_SHADOW_COLOR = 3'd1,
        REG_BG_ENABLE    = 3'd2,
        REG_BG_COLOR     = 3'd3,
        REG_GLYPH_LIMIT  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SLOT_MAIN  = 2'd0,
        SLOT_RIGHT = 2'd1,
        SLOT_BELOW = 2'd2
    } t_slot;

    typedef struct packed {
        logic [CLR_W-1:0]  fg_color;
        logic [CLR_W-1:0]  shadow_color;
        logic              bg_enable;
        logic [CLR_W-1:0]  bg_color;
        logic [CFG_DW-1:0] glyph_limit;
    } t_cfg;

    typedef struct packed {
        logic [GW-1:0]   mask;    // columns that write anything
        logic [GW-1:0]   set;     // glyph bit per column, column 0 leftmost
        logic [GW-1:0]   rok;     // right neighbour on screen
        logic            below;   // row below on screen
        logic [PX_W-1:0] ox;
        logic [PY_W-1:0] dy;
    } t_desc;

endpackage

>>> rtl/glyph_row_blitter_with_shadow.sv
// ----------------------------------------------------------------------------
// glyph_row_blitter_with_shadow - 16x16 glyph row renderer with drop shadow
// Holds the glyph store and turns draw items into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// item      in         push / full          action, glyph_index, glyph_row,
//                                           row_bits, origin_x, origin_y
// result    out        empty / pop          pixel_x, pixel_y, pixel_color,
//                                           last_write
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A draw causes up to 48 pixel writes through the single result port of
// the column sequencer; items keep flowing in while earlier draws are
// still being written out. A draw's first write passes the classification
// registers, the descriptor queue and r_cur on its way to the output.
// Synchronous active-low reset clears control state; the glyph store is
// not cleared. full rises when the four-entry descriptor queue, with a slot
// held for a draw still being classified, has no room left.
// ----------------------------------------------------------------------------
module glyph_row_blitter_with_shadow #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int MAX_GLYPHS    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_action,
    input  logic [grb_pkg::GI_W-1:0]    i_glyph_index,
    input  logic [grb_pkg::GCW-1:0]     i_glyph_row,
    input  logic [grb_pkg::GW-1:0]      i_row_bits,
    input  logic signed [15:0]          i_origin_x,
    input  logic signed [15:0]          i_origin_y,
    output logic                        empty,
    input  logic                        pop,
    output logic [grb_pkg::PX_W-1:0]    o_pixel_x,
    output logic [grb_pkg::PY_W-1:0]    o_pixel_y,
    output logic [grb_pkg::CLR_W-1:0]   o_pixel_color,
    output logic                        o_last_write,
    input  logic                        i_cfg_we,
    input  logic [grb_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [grb_pkg::CFG_DW-1:0]  i_cfg_data
);
    import grb_pkg::*;

    t_cfg            r_cfg;
    logic            accept;
    logic            q_push, q_pop, q_valid;
    t_desc           q_desc, q_head;
    logic [QCW-1:0]  q_count;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color     <= CLR_W'(15);
            r_cfg.shadow_color <= '0;
            r_cfg.bg_enable    <= 1'b0;
            r_cfg.bg_color     <= '0;
            r_cfg.glyph_limit  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FG_COLOR:     r_cfg.fg_color     <= i_cfg_data[CLR_W-1:0];
                REG_SHADOW_COLOR: r_cfg.shadow_color <= i_cfg_data[CLR_W-1:0];
                REG_BG_ENABLE:    r_cfg.bg_enable    <= i_cfg_data[0];
                REG_BG_COLOR:     r_cfg.bg_color     <= i_cfg_data[CLR_W-1:0];
                REG_GLYPH_LIMIT:  r_cfg.glyph_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    grb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_GLYPHS    (MAX_GLYPHS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_glyph_index (i_glyph_index),
        .i_glyph_row   (i_glyph_row),
        .i_row_bits    (i_row_bits),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_cfg         (r_cfg),
        .i_q_count     (q_count),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_q_desc      (q_desc)
    );

    grb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_desc),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    grb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_write  (o_last_write)
    );

endmodule

>>> rtl/grb_front.sv
// ----------------------------------------------------------------------------
// grb_front - item intake, glyph store and draw classification
// Loads write the store; draws are checked against the limit and the
// screen, the row is read, and a column descriptor is queued.
// ----------------------------------------------------------------------------
module grb_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int MAX_GLYPHS    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_action,
    input  logic [grb_pkg::GI_W-1:0]    i_glyph_index,
    input  logic [grb_pkg::GCW-1:0]     i_glyph_row,
    input  logic [grb_pkg::GW-1:0]      i_row_bits,
    input  logic [15:0]                 i_origin_x,
    input  logic [15:0]                 i_origin_y,
    input  grb_pkg::t_cfg               i_cfg,
    input  logic [grb_pkg::QCW-1:0]     i_q_count,
    output logic                        o_full,
    output logic                        o_q_push,
    output grb_pkg::t_desc              o_q_desc
);
    import grb_pkg::*;

    localparam int STORE_GLYPHS = (MAX_GLYPHS < 1024) ? MAX_GLYPHS : 1024;
    localparam int STORE_ROWS   = STORE_GLYPHS * GW;
    localparam int AW           = $clog2(STORE_ROWS);
    localparam logic signed [17:0] SW  = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SH  = 18'(SCREEN_HEIGHT);
    localparam logic [16:0]        MAXG = 17'(MAX_GLYPHS);

    logic [GW-1:0] r_store [STORE_ROWS];
    logic [GW-1:0] r_rd_bits;

    logic                r_s1_valid, n_s1_valid;
    logic [GW-1:0]       r_s1_on, n_s1_on;
    logic [GW-1:0]       r_s1_rok, n_s1_rok;
    logic                r_s1_below, n_s1_below;
    logic [PX_W-1:0]     r_s1_ox, n_s1_ox;
    logic [PY_W-1:0]     r_s1_dy, n_s1_dy;

    logic [AW-1:0]       addr;
    logic                in_store;
    logic                store_we;
    logic signed [17:0]  dx [GW];
    logic signed [17:0]  dy;
    logic [GW-1:0]       set_bits;
    logic [GW-1:0]       draw_mask;
    logic [13:0]         addr_full;

    always_comb begin
        addr_full = {i_glyph_index, i_glyph_row};
        addr      = addr_full[AW-1:0];
        in_store  = {7'd0, i_glyph_index} < MAXG;
        store_we  = i_accept && !i_action && in_store;

        dy = $signed({{2{i_origin_y[15]}}, i_origin_y}) + $signed({14'd0, i_glyph_row});
        for (int c = 0; c < GW; c++) begin
            dx[c]      = $signed({{2{i_origin_x[15]}}, i_origin_x}) + 18'(c);
            n_s1_on[c] = !dx[c][17] && (dx[c] < SW);
            n_s1_rok[c] = dx[c] < (SW - 18'sd1);
        end
        n_s1_below = dy < (SH - 18'sd1);
        n_s1_ox    = i_origin_x[PX_W-1:0];
        n_s1_dy    = dy[PY_W-1:0];
        // drop draws of unloaded glyphs and rows off screen here
        n_s1_valid = i_accept && i_action && in_store
                     && ({1'b0, i_glyph_index} < i_cfg.glyph_limit)
                     && !dy[17] && (dy < SH);

        for (int c = 0; c < GW; c++) begin
            set_bits[c] = r_rd_bits[GW-1-c];
        end
        draw_mask = r_s1_on & (set_bits | {GW{i_cfg.bg_enable}});

        o_q_push        = r_s1_valid && (draw_mask != '0);
        o_q_desc.mask   = draw_mask;
        o_q_desc.set    = set_bits;
        o_q_desc.rok    = r_s1_rok;
        o_q_desc.below  = r_s1_below;
        o_q_desc.ox     = r_s1_ox;
        o_q_desc.dy     = r_s1_dy;

        // reserve a queue slot for the draw in flight
        o_full = (i_q_count + QCW'(r_s1_valid)) >= QCW'(QDEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[addr] <= i_row_bits;
        end
        r_rd_bits <= r_store[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        r_s1_on    <= n_s1_on;
        r_s1_rok   <= n_s1_rok;
        r_s1_below <= n_s1_below;
        r_s1_ox    <= n_s1_ox;
        r_s1_dy    <= n_s1_dy;
    end

endmodule

>>> rtl/grb_queue.sv
// ----------------------------------------------------------------------------
// grb_queue - descriptor queue between front end and sequencer
// Small register FIFO; the head is always presented.
// ----------------------------------------------------------------------------
module grb_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  grb_pkg::t_desc          i_desc,
    input  logic                    i_pop,
    output logic                    o_valid,
    output grb_pkg::t_desc          o_head,
    output logic [grb_pkg::QCW-1:0] o_count
);
    import grb_pkg::*;

    t_desc            r_mem [QDEPTH];
    logic [QPW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_count;

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == QCW'(QDEPTH)))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("descriptor queue underflow");

endmodule

>>> rtl/grb_back.sv
// ----------------------------------------------------------------------------
// grb_back - pixel write sequencer
// Walks the marked columns left to right, up to three writes per column,
// and drives one write per cycle into the output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module grb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  grb_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  grb_pkg::t_desc            i_q_head,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [grb_pkg::PX_W-1:0]  o_pixel_x,
    output logic [grb_pkg::PY_W-1:0]  o_pixel_y,
    output logic [grb_pkg::CLR_W-1:0] o_pixel_color,
    output logic                      o_last_write
);
    import grb_pkg::*;

    t_desc             r_cur;
    logic [GW-1:0]     r_mask;
    logic [2:0]        r_sub;
    logic              r_sub_valid;
    logic              r_out_valid;
    logic [PX_W-1:0]   r_px;
    logic [PY_W-1:0]   r_py;
    logic [CLR_W-1:0]  r_pc;
    logic              r_last;

    logic [GCW-1:0]    col;
    logic              set_b, sh;
    logic [2:0]        fresh, slots, rem;
    t_slot             slot;
    logic [GW-1:0]     mask_next;
    logic              last, busy, adv, emit, load;
    logic [PX_W-1:0]   n_px;
    logic [PY_W-1:0]   n_py;
    logic [CLR_W-1:0]  n_pc;

    always_comb begin
        col = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                col = GCW'(i);
            end
        end
        set_b = r_cur.set[col];
        sh    = i_cfg.shadow_color != '0;
        fresh = set_b ? {sh & r_cur.below, sh & r_cur.rok[col], 1'b1} : 3'b001;
        slots = r_sub_valid ? r_sub : fresh;
        if (slots[0]) begin
            slot = SLOT_MAIN;
        end else if (slots[1]) begin
            slot = SLOT_RIGHT;
        end else begin
            slot = SLOT_BELOW;
        end
        rem       = slots & (slots - 3'd1);
        mask_next = (rem == '0) ? (r_mask & ~(GW'(1) << col)) : r_mask;
        last      = (rem == '0) && (mask_next == '0);

        busy = r_mask != '0;
        adv  = !r_out_valid || i_pop;
        emit = busy && adv;
        load = i_q_valid && (!busy || (emit && mask_next == '0));

        n_px = r_cur.ox + PX_W'(col);
        n_py = r_cur.dy;
        n_pc = set_b ? i_cfg.fg_color : i_cfg.bg_color;
        case (slot)
            SLOT_MAIN: begin
            end
            SLOT_RIGHT: begin
                n_px = r_cur.ox + PX_W'(col) + PX_W'(1);
                n_pc = i_cfg.shadow_color;
            end
            SLOT_BELOW: begin
                n_py = r_cur.dy + PY_W'(1);
                n_pc = i_cfg.shadow_color;
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop       = load;
    assign o_empty       = !r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last_write  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_head;
        end else if (emit) begin
            r_sub <= rem;
        end
        if (emit) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_pc   <= n_pc;
            r_last <= last;
        end
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_sub_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mask      <= i_q_head.mask;
                r_sub_valid <= 1'b0;
            end else if (emit) begin
                r_mask      <= mask_next;
                r_sub_valid <= rem != '0;
            end
            if (adv) begin
                r_out_valid <= busy;
            end
        end
    end

    a_sub_in_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_valid |-> r_mask != '0)
        else $error("pending shadow writes without an active column");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> i_q_head.mask != '0)
        else $error("queued descriptor carries no writes");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_mask == '0 || !r_sub_valid))
        else $error("final write left work in the current descriptor");

endmodule
